// ===== rtl/websocket_frame_deframer_macros.svh =====
// assertion macros for the websocket frame deframer
// used by wsd_parser, the rtl module that checks its own logic
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, checked out of reset
`define WSD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define WSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wsd_pkg.sv =====
// shared types and constants for the websocket frame deframer
// no dependencies
`default_nettype none

package wsd_pkg;

  // event codes carried with each result beat
  typedef enum logic [1:0] {
    EV_DATA  = 2'd0,
    EV_ERROR = 2'd1,
    EV_CLOSE = 2'd2
  } ev_kind_e;

  // opcodes of interest
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;

  // short length escape codes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // header byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES  = 4'd4;

  // widths
  localparam int unsigned LenW = 21;

  localparam logic [LenW-1:0] MAX_PAYLOAD_RST = 21'd1048576;

  // one result from the parser
  typedef struct packed {
    logic       valid;
    ev_kind_e   kind;
    logic [7:0] data;
    logic [3:0] op;
    logic       last;
    logic       eom;
  } wsd_result_t;

endpackage

`default_nettype wire

// ===== rtl/websocket_frame_deframer.sv =====
// websocket frame deframer: one received byte per beat, at most one result beat per byte
// path: input byte register, combinational parser, then result register
// throughput: one byte per cycle, the parser between input and result regs being combinational
// input stalls only while the result register is full and the receiver holds off
// reset: asynchronous active low; parser returns to first header byte, limit to 1048576
// depends on wsd_pkg, wsd_in_reg, wsd_parser, wsd_out_reg
`default_nettype none

module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // configuration
  input  wire logic            cfg_we_i,
  input  wire logic [LenW-1:0] cfg_wdata_i,     // max_payload
  // byte stream in
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [7:0]      s_axis_tdata,    // [7:0] rx_byte
  // result stream out
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [15:0]          m_axis_tdata,    // [7:0] payload_byte, [11:8] frame_opcode, rest 0
  output logic                 m_axis_tlast,    // last_of_frame
  output logic [2:0]           m_axis_tuser     // [1:0] event_kind, [2] end_of_message
);

  logic [LenW-1:0] max_payload_q;
  logic            adv;
  logic            out_free;
  logic [7:0]      in_byte;
  wsd_result_t     res;
  wsd_result_t     out_res;

  // payload limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_wdata_i;
    end
  end

  wsd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .out_free_i (out_free),
    .adv_o      (adv),
    .byte_o     (in_byte)
  );

  wsd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .byte_i        (in_byte),
    .max_payload_i (max_payload_q),
    .res_o         (res)
  );

  wsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .res_i       (res),
    .out_ready_i (m_axis_tready),
    .out_free_o  (out_free),
    .out_o       (out_res)
  );

  // pack the result beat
  assign m_axis_tvalid = out_res.valid;
  assign m_axis_tdata  = {4'h0, out_res.op, out_res.data};
  assign m_axis_tlast  = out_res.last;
  assign m_axis_tuser  = {out_res.eom, out_res.kind};

endmodule

`default_nettype wire

// ===== rtl/wsd_in_reg.sv =====
// input byte register with stream handshake
// depends on nothing but the flow control from the output stage
`default_nettype none

module wsd_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       out_free_i,
  output logic            adv_o,
  output logic [7:0]      byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  // the held byte moves on when the result register can take it
  assign adv_o      = valid_q & out_free_i;
  assign in_ready_o = ~valid_q | adv_o;
  assign accept     = in_valid_i & in_ready_o;
  assign byte_o     = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (adv_o) begin
      valid_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wsd_parser.sv =====
// frame header parser, unmasking and event generation
// depends on wsd_pkg and websocket_frame_deframer_macros.svh
`default_nettype none

`include "websocket_frame_deframer_macros.svh"

module wsd_parser
  import wsd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic [LenW-1:0] max_payload_i,
  output wsd_result_t          res_o
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_HALT
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [3:0]      op_q, op_d;
  logic            fin_q, fin_d;
  logic            mask_q, mask_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [LenW-1:0] len_q, len_d;
  logic            len_hi_q, len_hi_d;
  logic [31:0]     key_q, key_d;
  logic [LenW-1:0] pcnt_q, pcnt_d;

  logic [6:0]      len7;
  logic [LenW-1:0] ext_len;
  logic            ext_hi;
  logic [LenW:0]   pcnt_inc;
  logic            last;
  logic [7:0]      key_byte;
  logic [3:0]      cnt_dec;
  logic            chk_err;
  logic [LenW-1:0] chk_len;
  logic            chk_hi;
  wsd_result_t     res;

  assign len7     = byte_i[6:0];
  assign ext_len  = {len_q[LenW-9:0], byte_i};
  assign ext_hi   = len_hi_q | (|len_q[LenW-1:LenW-8]);
  assign pcnt_inc = {1'b0, pcnt_q} + {{LenW{1'b0}}, 1'b1};
  assign last     = pcnt_inc == {1'b0, len_q};
  assign key_byte = key_q[8*(3-pcnt_q[1:0]) +: 8];
  assign cnt_dec  = cnt_q - 4'd1;

  // length check at header end: zero, above 21 bits or over the limit
  assign chk_err = chk_hi | (chk_len == '0) | (chk_len > max_payload_i);

  always_comb begin
    phase_d  = phase_q;
    op_d     = op_q;
    fin_d    = fin_q;
    mask_d   = mask_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    len_hi_d = len_hi_q;
    key_d    = key_q;
    pcnt_d   = pcnt_q;
    chk_len  = len_q;
    chk_hi   = len_hi_q;
    res       = '0;
    res.kind  = EV_DATA;
    res.op    = op_q;

    unique case (phase_q)
      PH_HDR0: begin
        fin_d   = byte_i[7];
        op_d    = byte_i[3:0];
        phase_d = PH_HDR1;
      end
      PH_HDR1: begin
        mask_d   = byte_i[7];
        key_d    = '0;
        len_hi_d = 1'b0;
        if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
          len_d   = '0;
          cnt_d   = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          phase_d = PH_EXTLEN;
        end else begin
          len_d   = {{(LenW-7){1'b0}}, len7};
          chk_len = {{(LenW-7){1'b0}}, len7};
          chk_hi  = 1'b0;
          if (byte_i[7]) begin
            cnt_d   = MASK_BYTES;
            phase_d = PH_MASK;
          end else if (chk_err) begin
            phase_d  = PH_HALT;
            res.valid = 1'b1;
            res.kind  = EV_ERROR;
          end else begin
            pcnt_d  = '0;
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_EXTLEN: begin
        len_d    = ext_len;
        len_hi_d = ext_hi;
        cnt_d    = cnt_dec;
        chk_len  = ext_len;
        chk_hi   = ext_hi;
        if (cnt_dec == 4'd0) begin
          if (mask_q) begin
            cnt_d   = MASK_BYTES;
            phase_d = PH_MASK;
          end else if (chk_err) begin
            phase_d   = PH_HALT;
            res.valid = 1'b1;
            res.kind  = EV_ERROR;
          end else begin
            pcnt_d  = '0;
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_MASK: begin
        key_d = {key_q[23:0], byte_i};
        cnt_d = cnt_dec;
        if (cnt_dec == 4'd0) begin
          if (chk_err) begin
            phase_d   = PH_HALT;
            res.valid = 1'b1;
            res.kind  = EV_ERROR;
          end else begin
            pcnt_d  = '0;
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        pcnt_d = pcnt_inc[LenW-1:0];
        if (last) begin
          phase_d = PH_HDR0;
        end
        if (op_q == OP_CONT || op_q == OP_TEXT) begin
          res.valid = 1'b1;
          res.data  = byte_i ^ key_byte;
          res.last  = last;
          res.eom   = last & fin_q;
        end else if (op_q == OP_CLOSE && last) begin
          phase_d   = PH_HALT;
          res.valid = 1'b1;
          res.kind  = EV_CLOSE;
        end
      end
      PH_HALT: begin
        phase_d = PH_HALT;
      end
      default: begin
        phase_d = PH_HALT;
      end
    endcase
  end

  assign res_o = res;

  // parser state, updated once per byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      op_q     <= 4'h0;
      fin_q    <= 1'b0;
      mask_q   <= 1'b0;
      cnt_q    <= 4'd0;
      len_q    <= '0;
      len_hi_q <= 1'b0;
      key_q    <= '0;
      pcnt_q   <= '0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      op_q     <= op_d;
      fin_q    <= fin_d;
      mask_q   <= mask_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      len_hi_q <= len_hi_d;
      key_q    <= key_d;
      pcnt_q   <= pcnt_d;
    end
  end

  // checks
  `WSD_ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, phase_q == PH_HALT, phase_q == PH_HALT,
                   "parser left halt")
  `WSD_ASSERT_NOW(a_data_in_payload, clk_i, rst_ni, res.valid && res.kind == EV_DATA,
                  phase_q == PH_PAYLOAD && (op_q == OP_CONT || op_q == OP_TEXT),
                  "data beat outside a data frame payload")
  `WSD_ASSERT_NEXT(a_event_halts, clk_i, rst_ni, adv_i && res.valid && res.kind != EV_DATA,
                   phase_q == PH_HALT, "error or close did not halt")
  `WSD_ASSERT_NOW(a_cnt_nonzero, clk_i, rst_ni, phase_q == PH_EXTLEN || phase_q == PH_MASK,
                  cnt_q != 4'd0, "header byte count ran out")

endmodule

`default_nettype wire

// ===== rtl/wsd_out_reg.sv =====
// result register driving the master stream side
// depends on wsd_pkg
`default_nettype none

module wsd_out_reg
  import wsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire wsd_result_t res_i,
  input  wire logic        out_ready_i,
  output logic             out_free_o,
  output wsd_result_t      out_o
);

  logic        valid_q, valid_d;
  wsd_result_t res_q;
  logic        load;

  assign out_free_o = ~valid_q | out_ready_i;
  assign load       = adv_i & res_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  always_comb begin
    out_o       = res_q;
    out_o.valid = valid_q;
  end

endmodule

`default_nettype wire
